// ----- design/nsp_pkg.sv -----
// Package for the NMEA sentence parser: parser state and result types,
// and the character codes that the parser reacts to. No dependencies.
package nsp_pkg;

    localparam int ByteW  = 8;
    localparam int CountW = 7;

    localparam logic [ByteW-1:0] CH_NUL    = 8'h00;
    localparam logic [ByteW-1:0] CH_LF     = 8'h0A;
    localparam logic [ByteW-1:0] CH_CR     = 8'h0D;
    localparam logic [ByteW-1:0] CH_DOLLAR = 8'h24;
    localparam logic [ByteW-1:0] CH_STAR   = 8'h2A;
    localparam logic [ByteW-1:0] CH_COMMA  = 8'h2C;

    typedef struct packed {
        logic              xor_active;
        logic [ByteW-1:0]  xor_sum;
        logic [CountW-1:0] stored_length;
        logic [CountW-1:0] field_count;
        logic              full_flag;
        logic [ByteW-1:0]  hex_value;
        logic              hex_too_big;
        logic              hex_seen_digit;
        logic              hex_stopped;
    } t_state;

    typedef struct packed {
        logic [ByteW-1:0]  data_byte;
        logic              is_field_byte;
        logic [CountW-1:0] field_index;
        logic              field_end;
        logic              sentence_done;
        logic              checksum_ok;
        logic [ByteW-1:0]  running_checksum;
        logic              dropped;
    } t_result;

    localparam t_state STATE_CLEAR = '0;

endpackage

// ----- design/nsp_if.sv -----
// Channel interfaces for the NMEA sentence parser: received bytes in,
// per-byte results out. Valid/ready handshake. Depends on nsp_pkg.
interface nsp_in_if;
    logic                   valid;
    logic                   ready;
    logic [nsp_pkg::ByteW-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface nsp_out_if;
    logic                       valid;
    logic                       ready;
    logic [nsp_pkg::ByteW-1:0]  data_byte;
    logic                       is_field_byte;
    logic [nsp_pkg::CountW-1:0] field_index;
    logic                       field_end;
    logic                       sentence_done;
    logic                       checksum_ok;
    logic [nsp_pkg::ByteW-1:0]  running_checksum;
    logic                       dropped;

    modport source (output valid, output data_byte, output is_field_byte,
                    output field_index, output field_end, output sentence_done,
                    output checksum_ok, output running_checksum, output dropped,
                    input ready);
    modport sink   (input valid, input data_byte, input is_field_byte,
                    input field_index, input field_end, input sentence_done,
                    input checksum_ok, input running_checksum, input dropped,
                    output ready);
endinterface

// ----- design/nsp_step.sv -----
// Per-byte update of the NMEA parser: next sentence state and the result
// word for one received byte. Purely combinational. Depends on nsp_pkg.
module nsp_step #(
    parameter int BUFFER_BYTES = 83,
    parameter int MAX_FIELDS   = 80
) (
    input  logic [nsp_pkg::ByteW-1:0] i_byte,
    input  nsp_pkg::t_state           i_state,
    output nsp_pkg::t_state           o_state,
    output nsp_pkg::t_result          o_result
);
    import nsp_pkg::*;

    localparam logic [CountW-1:0] BufLimit   = CountW'(BUFFER_BYTES);
    localparam logic [CountW-1:0] FieldLimit = CountW'(MAX_FIELDS);

    logic       digit_valid;
    logic [3:0] digit_value;
    t_state     n_state;
    t_result    result;

    // Hex digit decode of the incoming byte.
    always_comb begin
        digit_valid = 1'b1;
        digit_value = 4'd0;
        if (i_byte >= 8'h30 && i_byte <= 8'h39) begin
            digit_value = 4'(i_byte - 8'h30);
        end else if (i_byte >= 8'h61 && i_byte <= 8'h66) begin
            digit_value = 4'(i_byte - 8'h57);
        end else if (i_byte >= 8'h41 && i_byte <= 8'h46) begin
            digit_value = 4'(i_byte - 8'h37);
        end else begin
            digit_valid = 1'b0;
        end
    end

    always_comb begin
        n_state                 = i_state;
        result.data_byte        = i_byte;
        result.is_field_byte    = 1'b0;
        result.field_index      = i_state.field_count;
        result.field_end        = 1'b0;
        result.sentence_done    = 1'b0;
        result.checksum_ok      = 1'b0;
        result.running_checksum = i_state.xor_sum;
        result.dropped          = 1'b0;

        if (i_byte == CH_NUL) begin
            // Ignored entirely.
        end else if (i_state.full_flag && i_byte != CH_DOLLAR) begin
            result.dropped = 1'b1;
        end else if (i_byte == CH_DOLLAR) begin
            n_state            = STATE_CLEAR;
            n_state.xor_active = 1'b1;
            result.field_index = '0;
            result.running_checksum = '0;
        end else if (i_byte == CH_CR || i_byte == CH_LF) begin
            if (i_state.stored_length != '0 && i_state.field_count != '0) begin
                result.sentence_done = 1'b1;
                result.checksum_ok   = i_state.hex_seen_digit && !i_state.hex_too_big
                                       && (i_state.hex_value == i_state.xor_sum);
            end
            n_state = STATE_CLEAR;
        end else if (i_byte == CH_STAR || i_byte == CH_COMMA) begin
            if (i_byte == CH_STAR) begin
                n_state.xor_active = 1'b0;
            end
            result.field_end      = 1'b1;
            n_state.stored_length = i_state.stored_length + 1'b1;
            n_state.field_count   = i_state.field_count + 1'b1;
            if (n_state.stored_length >= BufLimit || n_state.field_count >= FieldLimit) begin
                n_state.full_flag = 1'b1;
            end
            n_state.hex_value      = '0;
            n_state.hex_too_big    = 1'b0;
            n_state.hex_seen_digit = 1'b0;
            n_state.hex_stopped    = 1'b0;
            // The star itself is not part of the checksum.
            if (n_state.xor_active) begin
                n_state.xor_sum = i_state.xor_sum ^ i_byte;
            end
            result.running_checksum = n_state.xor_sum;
        end else begin
            result.is_field_byte  = 1'b1;
            n_state.stored_length = i_state.stored_length + 1'b1;
            if (n_state.stored_length >= BufLimit) begin
                n_state.full_flag = 1'b1;
            end
            if (!i_state.hex_stopped) begin
                if (digit_valid) begin
                    if (i_state.hex_value > 8'h0F) begin
                        n_state.hex_too_big = 1'b1;
                    end
                    n_state.hex_value      = {i_state.hex_value[3:0], digit_value};
                    n_state.hex_seen_digit = 1'b1;
                end else begin
                    n_state.hex_stopped = 1'b1;
                end
            end
            if (i_state.xor_active) begin
                n_state.xor_sum = i_state.xor_sum ^ i_byte;
            end
            result.running_checksum = n_state.xor_sum;
        end
    end

    assign o_state  = n_state;
    assign o_result = result;

endmodule

// ----- design/nmea_sentence_parser_core.sv -----
// Top level of the NMEA sentence parser: input register, per-byte update,
// result register. Depends on nsp_pkg, nsp_if and nsp_step.
//
// Usage:
//   i_rx carries one received character per word (rx_byte). o_res carries
//   exactly one result word per accepted byte: the echoed byte, field
//   content and field-close flags, the current field index, the running
//   XOR checksum, sentence end with checksum check, and a drop flag.
//   Path: an accepted byte lands in the input register, and its result is
//   then written to the result register that drives o_res.
//   Throughput: one byte per cycle while o_res is not held, set by the
//   combinational state update between the two registers.
//   Stall: when o_res is held, the result register keeps its word, the input
//   register still takes one more byte, and i_rx.ready then falls until the
//   result is taken. No word is lost or repeated.
//   Reset (i_rst_n low, synchronous): both registers empty, sentence state
//   cleared as after power-up; the XOR checksum starts at the next '$'.
module nmea_sentence_parser_core #(
    parameter int BUFFER_BYTES = 83,
    parameter int MAX_FIELDS   = 80
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    nsp_in_if.sink           i_rx,
    nsp_out_if.source        o_res
);
    import nsp_pkg::*;

    logic             r_in_valid;
    logic [ByteW-1:0] r_in_byte;
    t_state           r_state;
    t_state           n_state;
    logic             r_out_valid;
    t_result          r_out;
    t_result          n_out;
    logic             advance;

    assign advance    = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_rx.ready = !r_in_valid || advance;

    nsp_step #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .MAX_FIELDS   (MAX_FIELDS)
    ) u_step (
        .i_byte   (r_in_byte),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= STATE_CLEAR;
        end else begin
            if (i_rx.ready) begin
                r_in_valid <= i_rx.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.ready && i_rx.valid) begin
            r_in_byte <= i_rx.rx_byte;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.data_byte        = r_out.data_byte;
    assign o_res.is_field_byte    = r_out.is_field_byte;
    assign o_res.field_index      = r_out.field_index;
    assign o_res.field_end        = r_out.field_end;
    assign o_res.sentence_done    = r_out.sentence_done;
    assign o_res.checksum_ok      = r_out.checksum_ok;
    assign o_res.running_checksum = r_out.running_checksum;
    assign o_res.dropped          = r_out.dropped;

endmodule

// ----- bench/tb.sv -----
// Self-checking bench for nmea_sentence_parser_core: drives received bytes,
// predicts every result word and compares it field by field.
// Depends on nsp_pkg, nsp_if and the parser RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nsp_pkg::*;

    localparam int BUF_BYTES      = 83;
    localparam int FIELD_LIMIT    = 80;
    localparam int TARGET_BYTES   = 1900;
    localparam int WATCHDOG_LIMIT = 1000;

    // Keeps its own copy of the sentence state and the words still owed.
    class sentence_tracker;
        t_state      st;
        t_result     expected_q[$];
        int unsigned fails;
        int unsigned shown;

        function new();
            st    = STATE_CLEAR;
            fails = 0;
            shown = 0;
        endfunction

        function void clear_hex();
            st.hex_value      = '0;
            st.hex_too_big    = 1'b0;
            st.hex_seen_digit = 1'b0;
            st.hex_stopped    = 1'b0;
        endfunction

        function t_result split_byte(logic [ByteW-1:0] b);
            t_result r;
            int      d;
            r = '0;
            r.data_byte   = b;
            r.field_index = st.field_count;
            if (b == CH_NUL) begin
                r.running_checksum = st.xor_sum;
            end else if (st.full_flag && b != CH_DOLLAR) begin
                r.dropped          = 1'b1;
                r.running_checksum = st.xor_sum;
            end else if (b == CH_DOLLAR) begin
                st = STATE_CLEAR;
                st.xor_active = 1'b1;
                r.field_index = '0;
                r.running_checksum = '0;
            end else if (b == CH_CR || b == CH_LF) begin
                // An empty sentence or one without any delimiter just restarts.
                if (st.stored_length != 0 && st.field_count != 0) begin
                    r.sentence_done = 1'b1;
                    r.checksum_ok   = st.hex_seen_digit && !st.hex_too_big
                                      && st.hex_value == st.xor_sum;
                end
                r.running_checksum = st.xor_sum;
                st = STATE_CLEAR;
            end else if (b == CH_STAR || b == CH_COMMA) begin
                if (b == CH_STAR)
                    st.xor_active = 1'b0;
                r.field_end      = 1'b1;
                st.stored_length = st.stored_length + 1'b1;
                st.field_count   = st.field_count + 1'b1;
                if (st.stored_length >= BUF_BYTES || st.field_count >= FIELD_LIMIT)
                    st.full_flag = 1'b1;
                clear_hex();
                if (st.xor_active)
                    st.xor_sum = st.xor_sum ^ b;
                r.running_checksum = st.xor_sum;
            end else begin
                d = -1;
                if (b >= "0" && b <= "9")
                    d = int'(b - "0");
                else if (b >= "a" && b <= "f")
                    d = int'(b - "a") + 10;
                else if (b >= "A" && b <= "F")
                    d = int'(b - "A") + 10;
                r.is_field_byte  = 1'b1;
                st.stored_length = st.stored_length + 1'b1;
                if (st.stored_length >= BUF_BYTES)
                    st.full_flag = 1'b1;
                // Only the leading run of hex digits of a field is parsed.
                if (!st.hex_stopped) begin
                    if (d >= 0) begin
                        if (st.hex_value > 8'h0F)
                            st.hex_too_big = 1'b1;
                        st.hex_value      = {st.hex_value[3:0], 4'(d)};
                        st.hex_seen_digit = 1'b1;
                    end else begin
                        st.hex_stopped = 1'b1;
                    end
                end
                if (st.xor_active)
                    st.xor_sum = st.xor_sum ^ b;
                r.running_checksum = st.xor_sum;
            end
            return r;
        endfunction

        // Returns 1 when the byte does real work (neither NUL nor dropped).
        function bit note_byte(logic [ByteW-1:0] b);
            t_result r;
            r = split_byte(b);
            expected_q.push_back(r);
            return !(b == CH_NUL || r.dropped);
        endfunction

        function void compare(string name, logic [7:0] e, logic [7:0] a);
            if (a !== e) begin
                fails++;
                if (shown < 40) begin
                    shown++;
                    $display("%0t: %s expected %0h got %0h", $time, name, e, a);
                end
            end
        endfunction

        function void check_result(t_result got);
            t_result e;
            if (expected_q.size() == 0) begin
                fails++;
                if (shown < 40) begin
                    shown++;
                    $display("%0t: result word with nothing expected, expected none got byte %0h",
                             $time, got.data_byte);
                end
                return;
            end
            e = expected_q.pop_front();
            compare("data_byte", e.data_byte, got.data_byte);
            compare("is_field_byte", 8'(e.is_field_byte), 8'(got.is_field_byte));
            compare("field_index", 8'(e.field_index), 8'(got.field_index));
            compare("field_end", 8'(e.field_end), 8'(got.field_end));
            compare("sentence_done", 8'(e.sentence_done), 8'(got.sentence_done));
            compare("checksum_ok", 8'(e.checksum_ok), 8'(got.checksum_ok));
            compare("running_checksum", e.running_checksum, got.running_checksum);
            compare("dropped", 8'(e.dropped), 8'(got.dropped));
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    nsp_in_if  rx_ch ();
    nsp_out_if res_ch ();

    sentence_tracker  tracker = new();
    logic [ByteW-1:0] line_q[$];
    int unsigned      parsed_bytes = 0;
    int unsigned      quiet_cycles = 0;
    bit               calm_tx = 1'b0;
    bit               calm_rx = 1'b0;

    nmea_sentence_parser_core #(
        .BUFFER_BYTES (BUF_BYTES),
        .MAX_FIELDS   (FIELD_LIMIT)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_ch),
        .o_res   (res_ch)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [ByteW-1:0] hex_char(logic [3:0] n, bit lower);
        if (n < 10)
            return "0" + n;
        return 8'((lower ? "a" : "A") + n - 10);
    endfunction

    function automatic logic [ByteW-1:0] field_char();
        logic [ByteW-1:0] c;
        if ($urandom_range(0, 1)) begin
            c = hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
        end else begin
            do
                c = 8'($urandom_range(8'h20, 8'h7E));
            while (c == CH_DOLLAR || c == CH_STAR || c == CH_COMMA);
        end
        return c;
    endfunction

    // Builds the next line into line_q: mostly well-formed sentences with
    // random content, some overlong ones, some broken ones and raw noise.
    function automatic void compose_line();
        logic [ByteW-1:0] body[$];
        logic [ByteW-1:0] sum;
        int unsigned      kind;
        int unsigned      n;
        int unsigned      tail;
        bit               lower;
        line_q.delete();
        kind = $urandom_range(0, 99);
        if (kind >= 80) begin
            n = $urandom_range(1, 12);
            repeat (n) line_q.push_back(8'($urandom_range(0, 255)));
            return;
        end
        n = $urandom_range(1, 6);
        repeat (n) body.push_back(8'($urandom_range("A", "Z")));
        if (kind >= 55 && kind < 65) begin
            if ($urandom_range(0, 1)) begin
                body.push_back(CH_COMMA);
                n = $urandom_range(70, 100);
                repeat (n) body.push_back(field_char());
            end else begin
                n = $urandom_range(70, 90);
                repeat (n) begin
                    body.push_back(CH_COMMA);
                    if ($urandom_range(0, 3) == 0)
                        body.push_back(field_char());
                end
            end
        end else begin
            repeat ($urandom_range(0, 8)) begin
                body.push_back(CH_COMMA);
                n = $urandom_range(0, 10);
                repeat (n) body.push_back(field_char());
            end
        end
        sum = '0;
        foreach (body[i])
            sum = sum ^ body[i];
        line_q.push_back(CH_DOLLAR);
        foreach (body[i])
            line_q.push_back(body[i]);

        lower = 1'($urandom_range(0, 1));
        tail  = $urandom_range(0, 99);
        if (tail < 93)
            line_q.push_back(CH_STAR);
        if (tail >= 70 && tail < 80) begin
            sum = sum ^ 8'($urandom_range(1, 255));
        end else if (tail >= 80 && tail < 86) begin
            line_q.push_back(hex_char(4'($urandom_range(0, 15)), lower));
        end else if (tail >= 86 && tail < 93) begin
            // Leading blank or a C-style prefix is not skipped by the parser.
            if ($urandom_range(0, 1)) begin
                line_q.push_back(" ");
            end else begin
                line_q.push_back("0");
                line_q.push_back("x");
            end
        end
        if (tail < 93) begin
            line_q.push_back(hex_char(sum[7:4], lower));
            line_q.push_back(hex_char(sum[3:0], lower));
        end
        n = $urandom_range(0, 9);
        if (n < 8)
            line_q.push_back(CH_CR);
        if (n < 6 || n == 8)
            line_q.push_back(CH_LF);

        if (kind >= 65) begin
            case ($urandom_range(0, 3))
                0: void'(line_q.pop_front());
                1: begin
                    n = $urandom_range(1, line_q.size() - 1);
                    while (line_q.size() > n)
                        void'(line_q.pop_back());
                end
                2: begin
                    line_q.delete();
                    line_q.push_back(CH_DOLLAR);
                    line_q.push_back(CH_CR);
                end
                default: begin
                    line_q.delete();
                    line_q.push_back(CH_DOLLAR);
                    foreach (body[i])
                        if (body[i] != CH_COMMA)
                            line_q.push_back(body[i]);
                    line_q.push_back(CH_LF);
                end
            endcase
        end
        if ($urandom_range(0, 19) == 0)
            line_q.insert($urandom_range(0, line_q.size()), CH_NUL);
    endfunction

    task automatic send_byte(logic [ByteW-1:0] b);
        int unsigned gap;
        gap = calm_tx ? 0 : idle_len();
        if (gap != 0) begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do
            @(posedge i_clk);
        while (!rx_ch.ready);
        if (tracker.note_byte(b))
            parsed_bytes++;
    endtask

    // Holds the sender until every owed result word has come back.
    task automatic drain();
        rx_ch.valid <= 1'b0;
        do
            @(posedge i_clk);
        while (tracker.expected_q.size() != 0);
    endtask

    initial begin : stimulus
        logic [ByteW-1:0] opening[$];
        int unsigned      lines;
        opening = '{CH_LF, CH_NUL,
                    CH_DOLLAR, "G", CH_COMMA, "f", CH_STAR, "0", "d", CH_CR, CH_LF,
                    "A", CH_COMMA, "B", "F", CH_CR,
                    CH_DOLLAR, "1", "2", "3", CH_CR,
                    CH_DOLLAR, CH_STAR, 8'hFF, "0", CH_LF};
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (opening[i])
            send_byte(opening[i]);
        drain();
        lines = 0;
        while (parsed_bytes < TARGET_BYTES) begin
            calm_tx = ($urandom_range(0, 5) == 0);
            compose_line();
            foreach (line_q[i])
                send_byte(line_q[i]);
            lines++;
            if (lines % 150 == 0)
                drain();
        end
        drain();
        repeat (8) @(posedge i_clk);
        if (tracker.fails == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin : result_sink
        int unsigned stall_left;
        t_result     got;
        stall_left = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_ch.valid && res_ch.ready) begin
                got.data_byte        = res_ch.data_byte;
                got.is_field_byte    = res_ch.is_field_byte;
                got.field_index      = res_ch.field_index;
                got.field_end        = res_ch.field_end;
                got.sentence_done    = res_ch.sentence_done;
                got.checksum_ok      = res_ch.checksum_ok;
                got.running_checksum = res_ch.running_checksum;
                got.dropped          = res_ch.dropped;
                tracker.check_result(got);
            end
            if ($urandom_range(0, 299) == 0)
                calm_rx = !calm_rx;
            if (stall_left != 0)
                stall_left--;
            else if (!calm_rx && $urandom_range(0, 99) < 30)
                stall_left = idle_len();
            res_ch.ready <= (stall_left == 0);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

// ----- filelist.f -----
design/nsp_pkg.sv
design/nsp_if.sv
design/nsp_step.sv
design/nmea_sentence_parser_core.sv
bench/tb.sv
